>>> rtl/pdkr_pkg.sv
package pdkr_pkg;

  typedef logic [1:0] dir_t;
  typedef logic [2:0] key_t;
  typedef logic [1:0] op_t;

  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_UP   = 2'd1;
  localparam dir_t DIR_DOWN = 2'd2;

  localparam key_t KEY_UP        = 3'd0;
  localparam key_t KEY_DOWN      = 3'd1;
  localparam key_t KEY_ENTER     = 3'd2;
  localparam key_t KEY_BACKSPACE = 3'd3;
  localparam key_t KEY_M         = 3'd4;

  localparam op_t OP_BUTTON = 2'd0;
  localparam op_t OP_AXIS   = 2'd1;
  localparam op_t OP_POLL   = 2'd2;
  localparam op_t OP_REMOVE = 2'd3;

  localparam logic [3:0] BTN_DPAD_UP   = 4'd0;
  localparam logic [3:0] BTN_DPAD_DOWN = 4'd1;
  localparam logic [3:0] BTN_A         = 4'd2;
  localparam logic [3:0] BTN_B         = 4'd3;
  localparam logic [3:0] BTN_X         = 4'd4;

  localparam logic [2:0] AXIS_LEFT_Y = 3'd1;

  localparam logic [1:0] REG_PRESS_TH   = 2'd0;
  localparam logic [1:0] REG_RELEASE_TH = 2'd1;
  localparam logic [1:0] REG_DELAY      = 2'd2;
  localparam logic [1:0] REG_INTERVAL   = 2'd3;

  localparam logic [14:0] PRESS_TH_RST   = 15'd16000;
  localparam logic [14:0] RELEASE_TH_RST = 15'd8000;
  localparam logic [15:0] DELAY_RST      = 16'd400;
  localparam logic [15:0] INTERVAL_RST   = 16'd100;

  typedef struct packed {
    key_t key_id;
    logic key_down;
    logic is_repeat;
  } key_ev_t;

  // one queue entry: one or two key events from a single input beat
  typedef struct packed {
    logic    two;
    key_ev_t ev0;
    key_ev_t ev1;
  } evq_entry_t;

  typedef struct packed {
    logic [14:0] press_th;
    logic [14:0] release_th;
    logic [15:0] delay;
    logic [15:0] interval;
  } cfg_regs_t;

  function automatic key_t dir_key(dir_t dir);
    return (dir == DIR_UP) ? KEY_UP : KEY_DOWN;
  endfunction

endpackage

>>> rtl/pdkr_front.sv
module pdkr_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [1:0]             in_op,
  input  logic [3:0]             in_button,
  input  logic                   in_pressed,
  input  logic [2:0]             in_axis,
  input  logic signed [15:0]     in_axis_value,
  input  logic [31:0]            in_time_ms,
  input  pdkr_pkg::cfg_regs_t    cfg,
  output logic                   evq_push,
  output pdkr_pkg::evq_entry_t   evq_entry
);
  import pdkr_pkg::*;

  dir_t        dpad_r, dpad_nxt;
  dir_t        stick_r, stick_nxt;
  dir_t        held_r, held_nxt;
  logic [31:0] next_rpt_r, next_rpt_nxt;

  logic signed [16:0] val_ext;
  logic signed [16:0] pth_s, rth_s;
  logic [31:0]        poll_diff;
  logic [31:0]        press_due;
  logic [31:0]        repeat_due;
  dir_t               stick_dir;
  dir_t               dir_sel;
  logic               refresh;
  logic               single_en;
  key_ev_t            single_ev;
  logic               rel_en, prs_en;
  key_ev_t            rel_ev, prs_ev;

  assign val_ext    = {in_axis_value[15], in_axis_value};
  assign pth_s      = $signed({2'b00, cfg.press_th});
  assign rth_s      = $signed({2'b00, cfg.release_th});
  assign poll_diff  = in_time_ms - next_rpt_r;
  assign press_due  = in_time_ms + {16'd0, cfg.delay};
  assign repeat_due = in_time_ms + {16'd0, cfg.interval};

  always_comb begin
    dpad_nxt     = dpad_r;
    stick_nxt    = stick_r;
    held_nxt     = held_r;
    next_rpt_nxt = next_rpt_r;
    stick_dir    = stick_r;
    refresh      = 1'b0;
    single_en    = 1'b0;
    single_ev    = '0;
    rel_en       = 1'b0;
    prs_en       = 1'b0;
    case (in_op)
      OP_BUTTON: begin
        case (in_button)
          BTN_DPAD_UP: begin
            if (in_pressed) dpad_nxt = DIR_UP;
            else if (dpad_r == DIR_UP) dpad_nxt = DIR_NONE;
            refresh = 1'b1;
          end
          BTN_DPAD_DOWN: begin
            if (in_pressed) dpad_nxt = DIR_DOWN;
            else if (dpad_r == DIR_DOWN) dpad_nxt = DIR_NONE;
            refresh = 1'b1;
          end
          BTN_A: begin
            single_en = 1'b1;
            single_ev = '{key_id: KEY_ENTER, key_down: in_pressed, is_repeat: 1'b0};
          end
          BTN_B: begin
            single_en = 1'b1;
            single_ev = '{key_id: KEY_BACKSPACE, key_down: in_pressed, is_repeat: 1'b0};
          end
          BTN_X: begin
            single_en = 1'b1;
            single_ev = '{key_id: KEY_M, key_down: in_pressed, is_repeat: 1'b0};
          end
          default: ;
        endcase
      end
      OP_AXIS: begin
        if (in_axis == AXIS_LEFT_Y) begin
          if (val_ext <= -pth_s) stick_dir = DIR_UP;
          else if (val_ext >= pth_s) stick_dir = DIR_DOWN;
          else if (val_ext > -rth_s && val_ext < rth_s) stick_dir = DIR_NONE;
          if (stick_dir != stick_r) begin
            stick_nxt = stick_dir;
            refresh   = 1'b1;
          end
        end
      end
      OP_POLL: begin
        if (held_r != DIR_NONE && !poll_diff[31]) begin
          single_en    = 1'b1;
          single_ev    = '{key_id: dir_key(held_r), key_down: 1'b1, is_repeat: 1'b1};
          next_rpt_nxt = repeat_due;
        end
      end
      OP_REMOVE: begin
        dpad_nxt  = DIR_NONE;
        stick_nxt = DIR_NONE;
        refresh   = 1'b1;
      end
      default: ;
    endcase

    // d-pad wins over the stick
    dir_sel = (dpad_nxt != DIR_NONE) ? dpad_nxt : stick_nxt;
    if (refresh && dir_sel != held_r) begin
      rel_en   = (held_r != DIR_NONE);
      prs_en   = (dir_sel != DIR_NONE);
      held_nxt = dir_sel;
      if (prs_en) next_rpt_nxt = press_due;
    end
  end

  assign rel_ev = '{key_id: dir_key(held_r), key_down: 1'b0, is_repeat: 1'b0};
  assign prs_ev = '{key_id: dir_key(dir_sel), key_down: 1'b1, is_repeat: 1'b0};

  always_comb begin
    evq_entry.two = rel_en && prs_en;
    evq_entry.ev1 = prs_ev;
    if (single_en) evq_entry.ev0 = single_ev;
    else if (rel_en) evq_entry.ev0 = rel_ev;
    else evq_entry.ev0 = prs_ev;
  end

  assign evq_push = accept && (single_en || rel_en || prs_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpad_r     <= DIR_NONE;
      stick_r    <= DIR_NONE;
      held_r     <= DIR_NONE;
      next_rpt_r <= '0;
    end else if (accept) begin
      dpad_r     <= dpad_nxt;
      stick_r    <= stick_nxt;
      held_r     <= held_nxt;
      next_rpt_r <= next_rpt_nxt;
    end
  end

endmodule

>>> rtl/pdkr_evq.sv
module pdkr_evq #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pdkr_pkg::evq_entry_t push_entry,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output pdkr_pkg::key_ev_t    out_ev,
  output logic                 out_last
);
  import pdkr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  evq_entry_t    q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          idx_r;
  evq_entry_t    head;
  logic          beat;
  logic          deq;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head     = q_r[rd_ptr_r];
  assign out_ev   = idx_r ? head.ev1 : head.ev0;
  assign out_last = idx_r || !head.two;
  assign beat     = pop && !empty;
  assign deq      = beat && out_last;

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      idx_r    <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (deq) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (beat) idx_r <= !out_last;
      if (push && !deq) cnt_r <= cnt_r + 1'b1;
      else if (deq && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> rtl/pad_direction_key_repeater.sv
// Gamepad direction key repeater. Input beats (button, axis, poll, pad removed)
// are taken on in_push while in_full is low; each beat is classified and the
// direction state updated in the cycle it is accepted, giving zero, one or two
// key events (release of the old direction before press of the new one). The
// events sit in an EVQ_DEPTH-entry queue and leave one per out_pop beat, with
// out_last set on the final event of an input beat. A new input beat can be
// taken every cycle while the queue has room; the output side drains one key
// event per cycle while out_pop is high, so a beat that yields two events
// takes two pops to leave. Configuration writes are always ready; they are
// meant to be issued only while the block is idle.
module pad_direction_key_repeater #(
  parameter int EVQ_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_button,
  input  logic        in_pressed,
  input  logic [2:0]  in_axis,
  input  logic signed [15:0] in_axis_value,
  input  logic [31:0] in_time_ms,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_key_id,
  output logic        out_key_down,
  output logic        out_is_repeat,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pdkr_pkg::*;

  cfg_regs_t  cfg_r;
  logic       accept;
  logic       evq_push;
  evq_entry_t evq_entry;
  key_ev_t    out_ev;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_th   <= PRESS_TH_RST;
      cfg_r.release_th <= RELEASE_TH_RST;
      cfg_r.delay      <= DELAY_RST;
      cfg_r.interval   <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESS_TH:   cfg_r.press_th   <= cfg_data[14:0];
        REG_RELEASE_TH: cfg_r.release_th <= cfg_data[14:0];
        REG_DELAY:      cfg_r.delay      <= cfg_data;
        REG_INTERVAL:   cfg_r.interval   <= cfg_data;
        default: ;
      endcase
    end
  end

  pdkr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_op         (in_op),
    .in_button     (in_button),
    .in_pressed    (in_pressed),
    .in_axis       (in_axis),
    .in_axis_value (in_axis_value),
    .in_time_ms    (in_time_ms),
    .cfg           (cfg_r),
    .evq_push      (evq_push),
    .evq_entry     (evq_entry)
  );

  pdkr_evq #(
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (evq_push),
    .push_entry (evq_entry),
    .full       (in_full),
    .empty      (out_empty),
    .pop        (out_pop),
    .out_ev     (out_ev),
    .out_last   (out_last)
  );

  assign out_key_id    = out_ev.key_id;
  assign out_key_down  = out_ev.key_down;
  assign out_is_repeat = out_ev.is_repeat;

endmodule

>>> rtl/pdkr_checker.sv
module pdkr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_key_id,
  input logic       out_key_down,
  input logic       out_is_repeat,
  input logic       out_last
);
  import pdkr_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queue not empty after reset");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_key_id == KEY_UP || out_key_id == KEY_DOWN ||
                    out_key_id == KEY_ENTER || out_key_id == KEY_BACKSPACE ||
                    out_key_id == KEY_M))
    else $error("key id out of range");

  a_repeat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_is_repeat |->
      out_key_down && out_last && (out_key_id == KEY_UP || out_key_id == KEY_DOWN))
    else $error("bad repeat beat");

  a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_last |->
      !out_key_down && !out_is_repeat && (out_key_id == KEY_UP || out_key_id == KEY_DOWN))
    else $error("first of a pair is not a direction release");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty &&
      $stable({out_key_id, out_key_down, out_is_repeat, out_last}))
    else $error("stalled result changed");

endmodule

bind pad_direction_key_repeater pdkr_checker u_pdkr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_key_id    (out_key_id),
  .out_key_down  (out_key_down),
  .out_is_repeat (out_is_repeat),
  .out_last      (out_last)
);

>>> dv/key_event_checker.sv
`timescale 1ns / 1ps

module key_event_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_button,
  input  logic        in_pressed,
  input  logic [2:0]  in_axis,
  input  logic [15:0] in_axis_value,
  input  logic [31:0] in_time_ms,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [2:0]  out_key_id,
  input  logic        out_key_down,
  input  logic        out_is_repeat,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);
  import pdkr_pkg::*;

  typedef struct packed {
    key_t key;
    logic down;
    logic rep;
    logic last;
  } key_beat_t;

  key_beat_t   expected_keys[$];
  key_beat_t   fresh_keys[$];

  dir_t        dpad_dir;
  dir_t        stick_dir;
  dir_t        held_dir;
  logic [31:0] repeat_due;
  logic [14:0] press_th;
  logic [14:0] release_th;
  logic [15:0] delay_ms;
  logic [15:0] interval_ms;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic add_key(key_t key, logic down, logic rep);
    key_beat_t kb;
    kb = '{key: key, down: down, rep: rep, last: 1'b0};
    fresh_keys = {fresh_keys, kb};
  endtask

  // d-pad wins over the stick; release of the old key precedes press of the new one
  task automatic settle_held(logic [31:0] stamp);
    dir_t want;
    want = (dpad_dir != DIR_NONE) ? dpad_dir : stick_dir;
    if (want != held_dir) begin
      if (held_dir != DIR_NONE)
        add_key((held_dir == DIR_UP) ? KEY_UP : KEY_DOWN, 1'b0, 1'b0);
      held_dir = want;
      if (held_dir != DIR_NONE) begin
        add_key((held_dir == DIR_UP) ? KEY_UP : KEY_DOWN, 1'b1, 1'b0);
        repeat_due = stamp + {16'd0, delay_ms};
      end
    end
  endtask

  task automatic predict_keys();
    int          v;
    int          pth;
    int          rth;
    dir_t        sdir;
    logic [31:0] since;
    v = int'($signed(in_axis_value));
    pth = int'(press_th);
    rth = int'(release_th);
    fresh_keys.delete();
    case (in_op)
      OP_BUTTON: begin
        case (in_button)
          BTN_DPAD_UP: begin
            if (in_pressed) dpad_dir = DIR_UP;
            else if (dpad_dir == DIR_UP) dpad_dir = DIR_NONE;
            settle_held(in_time_ms);
          end
          BTN_DPAD_DOWN: begin
            if (in_pressed) dpad_dir = DIR_DOWN;
            else if (dpad_dir == DIR_DOWN) dpad_dir = DIR_NONE;
            settle_held(in_time_ms);
          end
          BTN_A: add_key(KEY_ENTER, in_pressed, 1'b0);
          BTN_B: add_key(KEY_BACKSPACE, in_pressed, 1'b0);
          BTN_X: add_key(KEY_M, in_pressed, 1'b0);
          default: ;
        endcase
      end
      OP_AXIS: begin
        if (in_axis == AXIS_LEFT_Y) begin
          sdir = stick_dir;
          if (v <= -pth) sdir = DIR_UP;
          else if (v >= pth) sdir = DIR_DOWN;
          else if (v > -rth && v < rth) sdir = DIR_NONE;
          if (sdir != stick_dir) begin
            stick_dir = sdir;
            settle_held(in_time_ms);
          end
        end
      end
      OP_POLL: begin
        since = in_time_ms - repeat_due;
        if (held_dir != DIR_NONE && !since[31]) begin
          add_key((held_dir == DIR_UP) ? KEY_UP : KEY_DOWN, 1'b1, 1'b1);
          repeat_due = in_time_ms + {16'd0, interval_ms};
        end
      end
      default: begin
        dpad_dir = DIR_NONE;
        stick_dir = DIR_NONE;
        settle_held(in_time_ms);
      end
    endcase
    if (fresh_keys.size() > 0)
      fresh_keys[fresh_keys.size() - 1].last = 1'b1;
    expected_keys = {expected_keys, fresh_keys};
  endtask

  task automatic check_key();
    key_beat_t want;
    if (expected_keys.size() == 0) begin
      report_mismatch("key beat with nothing expected",
                      32'({out_key_id, out_key_down, out_is_repeat, out_last}), 32'd0);
      return;
    end
    want = expected_keys.pop_front();
    if (out_key_id !== want.key)
      report_mismatch("key_id", 32'(out_key_id), 32'(want.key));
    if (out_key_down !== want.down)
      report_mismatch("key_down", 32'(out_key_down), 32'(want.down));
    if (out_is_repeat !== want.rep)
      report_mismatch("is_repeat", 32'(out_is_repeat), 32'(want.rep));
    if (out_last !== want.last)
      report_mismatch("last", 32'(out_last), 32'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dpad_dir = DIR_NONE;
      stick_dir = DIR_NONE;
      held_dir = DIR_NONE;
      repeat_due = '0;
      press_th = PRESS_TH_RST;
      release_th = RELEASE_TH_RST;
      delay_ms = DELAY_RST;
      interval_ms = INTERVAL_RST;
      expected_keys.delete();
    end else begin
      if (out_pop && !out_empty)
        check_key();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRESS_TH:   press_th = cfg_data[14:0];
          REG_RELEASE_TH: release_th = cfg_data[14:0];
          REG_DELAY:      delay_ms = cfg_data;
          REG_INTERVAL:   interval_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        predict_keys();
    end
    pending <= expected_keys.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pdkr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_op;
  logic [3:0]  in_button;
  logic        in_pressed;
  logic [2:0]  in_axis;
  logic [15:0] in_axis_value;
  logic [31:0] in_time_ms;
  logic        out_empty;
  logic        out_pop;
  logic [2:0]  out_key_id;
  logic        out_key_down;
  logic        out_is_repeat;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          key_errors;
  int          keys_pending;

  logic        feed_gaps;
  logic        pop_gaps;
  logic [31:0] now_ms;
  logic [14:0] cur_press;
  logic [14:0] cur_release;
  logic [15:0] cur_delay;
  logic [15:0] cur_interval;

  pad_direction_key_repeater dut (.*);

  key_event_checker checker_i (
    .errors  (key_errors),
    .pending (keys_pending),
    .*
  );

  always #6 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  always begin
    @(posedge clk);
    if (pop_gaps && $urandom_range(0, 5) == 0) begin
      out_pop <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    out_pop <= 1'b1;
  end

  task automatic send_pad_event(op_t op, logic [3:0] btn, logic prs, logic [2:0] ax,
                                logic [15:0] val, logic [31:0] stamp);
    if (feed_gaps && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_op         <= op;
    in_button     <= btn;
    in_pressed    <= prs;
    in_axis       <= ax;
    in_axis_value <= val;
    in_time_ms    <= stamp;
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (keys_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [15:0] pth, logic [15:0] rth, logic [15:0] dly,
                            logic [15:0] ivl);
    drain();
    write_reg(REG_PRESS_TH, pth);
    write_reg(REG_RELEASE_TH, rth);
    write_reg(REG_DELAY, dly);
    write_reg(REG_INTERVAL, ivl);
    cfg_valid <= 1'b0;
    cur_press = pth[14:0];
    cur_release = rth[14:0];
    cur_delay = dly;
    cur_interval = ivl;
  endtask

  // values around both thresholds on either side, plus zero, the rails and a random value
  function automatic logic [15:0] stick_value();
    int p;
    int r;
    p = int'(cur_press);
    r = int'(cur_release);
    case ($urandom_range(0, 11))
      0: return 16'(-p);
      1: return 16'(p);
      2: return 16'(-p + 1);
      3: return 16'(p - 1);
      4: return 16'(-r);
      5: return 16'(r);
      6: return 16'(-r + 1);
      7: return 16'(r - 1);
      8: return 16'd0;
      9: return 16'h8000;
      10: return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic directed_events();
    send_pad_event(OP_BUTTON, BTN_A, 1'b1, 3'd0, 16'd0, 32'd10);
    send_pad_event(OP_BUTTON, BTN_A, 1'b0, 3'd0, 16'd0, 32'd11);
    send_pad_event(OP_BUTTON, BTN_B, 1'b1, 3'd0, 16'd0, 32'd12);
    send_pad_event(OP_BUTTON, BTN_X, 1'b1, 3'd0, 16'd0, 32'd13);
    send_pad_event(OP_BUTTON, 4'hF, 1'b1, 3'd0, 16'd0, 32'd14);
    send_pad_event(OP_BUTTON, BTN_DPAD_UP, 1'b1, 3'd0, 16'd0, 32'd100);
    send_pad_event(OP_BUTTON, BTN_DPAD_DOWN, 1'b1, 3'd0, 16'd0, 32'd120);
    send_pad_event(OP_BUTTON, BTN_DPAD_UP, 1'b0, 3'd0, 16'd0, 32'd130);
    send_pad_event(OP_AXIS, BTN_A, 1'b0, AXIS_LEFT_Y, 16'h8000, 32'd140);
    send_pad_event(OP_BUTTON, BTN_DPAD_DOWN, 1'b0, 3'd0, 16'd0, 32'd150);
    send_pad_event(OP_AXIS, BTN_A, 1'b0, AXIS_LEFT_Y, 16'(-10000), 32'd160);
    send_pad_event(OP_AXIS, BTN_A, 1'b0, AXIS_LEFT_Y, 16'(-7999), 32'd170);
    send_pad_event(OP_AXIS, BTN_A, 1'b0, 3'd0, 16'h8000, 32'd180);
    send_pad_event(OP_AXIS, BTN_A, 1'b0, 3'd5, 16'h7FFF, 32'd190);
    // down press just before the timestamp wraps
    send_pad_event(OP_AXIS, 4'd0, 1'b0, AXIS_LEFT_Y, 16'h7FFF, 32'hFFFF_FF00);
    send_pad_event(OP_POLL, 4'd0, 1'b0, 3'd0, 16'd0, 32'hFFFF_FFF0);
    send_pad_event(OP_POLL, 4'd0, 1'b0, 3'd0, 16'd0, 32'h0000_0090);
    send_pad_event(OP_POLL, 4'd0, 1'b0, 3'd0, 16'd0, 32'h0000_00F3);
    send_pad_event(OP_POLL, 4'd0, 1'b0, 3'd0, 16'd0, 32'h0000_1000);
    send_pad_event(OP_REMOVE, 4'd0, 1'b0, 3'd0, 16'd0, 32'h0000_1010);
    send_pad_event(OP_REMOVE, 4'd0, 1'b0, 3'd0, 16'd0, 32'h0000_1020);
    send_pad_event(OP_POLL, 4'd0, 1'b0, 3'd0, 16'd0, 32'h0000_2000);
    send_pad_event(OP_AXIS, 4'd0, 1'b0, AXIS_LEFT_Y, 16'd16000, 32'h0000_2010);
    send_pad_event(OP_AXIS, 4'd0, 1'b0, AXIS_LEFT_Y, 16'(-16000), 32'h0000_2020);
    send_pad_event(OP_AXIS, 4'd0, 1'b0, AXIS_LEFT_Y, 16'd8000, 32'h0000_2030);
    send_pad_event(OP_REMOVE, 4'd0, 1'b0, 3'd0, 16'd0, 32'h0000_2040);
  endtask

  task automatic random_events(int count);
    int          kind;
    op_t         op;
    logic [3:0]  btn;
    logic        prs;
    logic [2:0]  ax;
    logic [15:0] val;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      btn = 4'($urandom_range(0, 15));
      prs = 1'($urandom_range(0, 1));
      ax = 3'($urandom_range(0, 5));
      val = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) == 0)
        now_ms = $urandom();
      else if ($urandom_range(0, 9) == 0)
        now_ms += $urandom_range(0, 2 * int'(cur_delay));
      else
        now_ms += $urandom_range(0, int'(cur_interval) + 60);
      if (kind < 7) begin
        op = op_t'($urandom_range(0, 3));
        send_pad_event(op, btn, prs, ax, val, $urandom());
      end else if (kind < 42) begin
        send_pad_event(OP_POLL, btn, prs, ax, val, now_ms);
      end else if (kind < 67) begin
        if ($urandom_range(0, 9) != 0)
          ax = AXIS_LEFT_Y;
        send_pad_event(OP_AXIS, btn, prs, ax, stick_value(), now_ms);
      end else if (kind < 87) begin
        btn = ($urandom_range(0, 1) == 0) ? BTN_DPAD_UP : BTN_DPAD_DOWN;
        send_pad_event(OP_BUTTON, btn, prs, ax, val, now_ms);
      end else if (kind < 97) begin
        btn = BTN_A + 4'($urandom_range(0, 2));
        send_pad_event(OP_BUTTON, btn, prs, ax, val, now_ms);
      end else begin
        send_pad_event(OP_REMOVE, btn, prs, ax, val, now_ms);
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_push       <= 1'b0;
    in_op         <= OP_POLL;
    in_button     <= '0;
    in_pressed    <= 1'b0;
    in_axis       <= '0;
    in_axis_value <= '0;
    in_time_ms    <= '0;
    out_pop       <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_PRESS_TH;
    cfg_data      <= '0;
    feed_gaps = 1'b1;
    pop_gaps = 1'b1;
    now_ms = 32'd5000;
    cur_press = PRESS_TH_RST;
    cur_release = RELEASE_TH_RST;
    cur_delay = DELAY_RST;
    cur_interval = INTERVAL_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_events();
    random_events(300);

    set_config(16'd0, 16'd0, 16'd1, 16'd1);
    pop_gaps = 1'b0;
    random_events(250);

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pop_gaps = 1'b1;
    feed_gaps = 1'b0;
    random_events(250);

    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    feed_gaps = 1'b1;
    now_ms = 32'hFFFF_F000;
    random_events(250);

    // release above press: hysteresis band inverted
    set_config(16'd12000, 16'd20000, 16'd30, 16'd5);
    random_events(250);

    set_config(16'd20000, 16'd5000, 16'd50, 16'd20);
    feed_gaps = 1'b0;
    pop_gaps = 1'b0;
    random_events(300);

    drain();
    repeat (10) @(posedge clk);
    if (key_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> pad_direction_key_repeater.f
rtl/pdkr_pkg.sv
rtl/pdkr_front.sv
rtl/pdkr_evq.sv
rtl/pad_direction_key_repeater.sv
rtl/pdkr_checker.sv
dv/key_event_checker.sv
dv/tb.sv
